### hw/rtl/salru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
package salru_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_SET_BITS = 4'd4;
    localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [CFG_DATA_W-1:0] RST_WAYS = 4'd1;

    localparam int CNT_W = 32;

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_sts;

endpackage

### hw/rtl/salru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/salru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_ctrl
// Controller state machine: clearing sweep, accept, lookup and commit.
// ----------------------------------------------------------------------------
module salru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  salru_pkg::t_dp_sts i_sts,
    output salru_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_LOOK = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/salru_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_dp
// Datapath: configuration, set memory, tag compare, LRU update and counters.
// ----------------------------------------------------------------------------
module salru_dp #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS = 8,
    parameter int ADDR_WIDTH = 64,
    parameter int IN_W = 64,
    parameter int OUT_W = 112
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [IN_W-1:0]                     i_s_tdata,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [OUT_W-1:0]                    o_m_tdata,
    input  salru_pkg::t_dp_cmd                  i_cmd,
    output salru_pkg::t_dp_sts                  o_sts
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int DEPTH = 1 << MAX_SET_BITS;
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int ROW_W = MAX_WAYS * (1 + ADDR_WIDTH + WAY_W);
    localparam int TAG_BASE = MAX_WAYS;
    localparam int RANK_BASE = MAX_WAYS + MAX_WAYS * ADDR_WIDTH;
    localparam int CW = salru_pkg::CNT_W;

    logic [salru_pkg::CFG_DATA_W-1:0] r_set_bits;
    logic [salru_pkg::CFG_DATA_W-1:0] r_off_bits;
    logic [salru_pkg::CFG_DATA_W-1:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= salru_pkg::RST_SET_BITS;
            r_off_bits <= salru_pkg::RST_OFFSET_BITS;
            r_ways <= salru_pkg::RST_WAYS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                salru_pkg::CFG_SET_BITS: r_set_bits <= i_cfg_data;
                salru_pkg::CFG_OFFSET_BITS: r_off_bits <= i_cfg_data;
                salru_pkg::CFG_WAYS: r_ways <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [4:0]            sb_eff;
    logic [5:0]            ways_eff;
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [SET_W-1:0]      set_mask;
    logic [AW-1:0]         set_in;
    logic [ADDR_WIDTH-1:0] tag_in;

    always_comb begin
        sb_eff = ({1'b0, r_set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                          : {1'b0, r_set_bits};
        if (r_ways == '0) begin
            ways_eff = 6'd1;
        end else if ({2'b0, r_ways} > 6'(MAX_WAYS)) begin
            ways_eff = 6'(MAX_WAYS);
        end else begin
            ways_eff = {2'b0, r_ways};
        end
        addr = i_s_tdata[ADDR_WIDTH-1:0];
        addr_sh = addr >> r_off_bits;
        set_mask = ~({SET_W{1'b1}} << sb_eff);
        set_in = AW'(addr_sh[SET_W-1:0] & set_mask);
        tag_in = addr >> (6'(r_off_bits) + 6'(sb_eff));
    end

    logic [AW-1:0]         r_set;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic [AW-1:0]         r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= set_in;
            r_tag <= tag_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    logic [ROW_W-1:0] rdata;
    logic [ROW_W-1:0] wrow;

    salru_ram #(
        .WIDTH(ROW_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.clear | i_cmd.commit),
        .i_waddr(i_cmd.clear ? r_clr_idx : r_set),
        .i_wdata(i_cmd.clear ? '0 : wrow),
        .i_re   (i_cmd.accept),
        .i_raddr(set_in),
        .o_rdata(rdata)
    );

    logic [MAX_WAYS-1:0]   valid;
    logic [ADDR_WIDTH-1:0] tags [MAX_WAYS];
    logic [WAY_W-1:0]      ranks [MAX_WAYS];
    logic [MAX_WAYS-1:0]   active;
    logic [MAX_WAYS-1:0]   hit_vec;
    logic [MAX_WAYS-1:0]   free_vec;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      vic_way;
    logic [WAY_W-1:0]      sel_way;
    logic [WAY_W-1:0]      sel_rank;
    logic                  hit;
    logic                  fill;
    logic                  evict;
    logic [MAX_WAYS-1:0]   n_valid;
    logic [WAY_W-1:0]      n_ranks [MAX_WAYS];

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            valid[w] = rdata[w];
            tags[w] = rdata[TAG_BASE + w*ADDR_WIDTH +: ADDR_WIDTH];
            ranks[w] = rdata[RANK_BASE + w*WAY_W +: WAY_W];
            active[w] = (6'(w) < ways_eff);
            hit_vec[w] = active[w] && valid[w] && (tags[w] == r_tag);
            free_vec[w] = active[w] && !valid[w];
        end
        hit_way = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_way = WAY_W'(w);
            end
        end
        vic_way = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (active[w] && (ranks[w] > ranks[vic_way])) begin
                vic_way = WAY_W'(w);
            end
        end
        hit = |hit_vec;
        fill = !hit && (|free_vec);
        evict = !hit && !(|free_vec);
        sel_way = hit ? hit_way : (fill ? free_way : vic_way);
        sel_rank = ranks[sel_way];
        n_valid = valid;
        n_valid[sel_way] = 1'b1;
        wrow = rdata;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == sel_way) begin
                n_ranks[w] = '0;
            end else if (valid[w] && (fill || (ranks[w] < sel_rank))) begin
                n_ranks[w] = ranks[w] + 1'b1;
            end else begin
                n_ranks[w] = ranks[w];
            end
            wrow[RANK_BASE + w*WAY_W +: WAY_W] = n_ranks[w];
            if (WAY_W'(w) == sel_way) begin
                wrow[TAG_BASE + w*ADDR_WIDTH +: ADDR_WIDTH] = r_tag;
            end
        end
        wrow[MAX_WAYS-1:0] = n_valid;
    end

    logic [CW-1:0] r_hits;
    logic [CW-1:0] r_misses;
    logic [CW-1:0] r_evicts;
    logic [CW-1:0] n_hits;
    logic [CW-1:0] n_misses;
    logic [CW-1:0] n_evicts;

    always_comb begin
        n_hits = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (hit) begin
            n_hits = (&r_hits) ? r_hits : r_hits + 1'b1;
        end else begin
            n_misses = (&r_misses) ? r_misses : r_misses + 1'b1;
        end
        if (evict) begin
            n_evicts = (&r_evicts) ? r_evicts : r_evicts + 1'b1;
        end
    end

    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_evict;
    logic [SET_W-1:0]      r_out_set;
    logic [WAY_W-1:0]      r_out_way;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_misses <= '0;
            r_evicts <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_hits <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit <= hit;
            r_evict <= evict;
            r_out_set <= SET_W'(r_set);
            r_out_way <= sel_way;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = OUT_W'({r_evicts, r_misses, r_hits, r_out_way, r_out_set,
                               r_evict, r_hit});
    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_sts.clear_last = (r_clr_idx == AW'(DEPTH - 1));

endmodule

### hw/rtl/set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Set-associative cache simulator with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each transaction on the slave stream carries one byte address in tdata.
// The block picks the set and tag from the configured offset and set-index
// bit counts, looks the tag up across the active ways and returns one result
// transaction on the master stream: hit, eviction, set, way and the three
// saturating running totals.
// Configuration registers are written over the cfg channel, which is always
// ready; they should only change while the block is idle.
// Each address is handled in order: the set row is read from the set memory,
// then all ways are compared, the row is updated and the result register is
// loaded. A new address is accepted only after the previous one has written
// its set row back, and the result appears in the cycle after that write-back.
// After reset a clearing sweep writes every set row, one row per cycle,
// while the slave stream is not ready.
// If the receiver stalls, one result waits in the output register and the
// next address is still accepted; its lookup then holds until the result
// register frees.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Slave stream: tdata holds address.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((ADDR_WIDTH + 7) / 8) * 8-1:0] i_s_tdata,
    // Master stream: tdata holds hit, evicted, set_index, way_touched,
    // hits_total, misses_total, evictions_total, from the lowest bit up.
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output logic [((2 + (MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)
                    + (MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1) + 96 + 7) / 8) * 8-1:0]
                 o_m_tdata
);

    localparam int IN_W = ((ADDR_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = ((2 + (MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)
                             + (MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1) + 96 + 7) / 8) * 8;

    salru_pkg::t_dp_cmd cmd;
    salru_pkg::t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    salru_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    salru_dp #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .ADDR_WIDTH  (ADDR_WIDTH),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

### hw/rtl/salru_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salru_chk
// Port-level checker of the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
module salru_chk #(
    parameter int IN_W = 64,
    parameter int OUT_W = 112
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic [IN_W-1:0]  i_s_tdata,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("Result valid dropped while stalled.");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("Result data changed while stalled.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("Second address accepted during a lookup.");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> !o_m_tdata[1])
        else $error("Result reports both hit and eviction.");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("Result appeared without a matching address.");

endmodule

bind set_assoc_cache_lru_sim salru_chk #(
    .IN_W (IN_W),
    .OUT_W(OUT_W)
) u_salru_chk (.*);

### tb/tb_set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim
// Self-checking testbench of the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
// An initial block queues addresses and configuration phases. A driver
// offers the addresses on the slave stream with random gaps, a monitor takes
// results from the master stream with random stalls, and a cache predictor
// computes every expected result, which the monitor compares field by field.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim;

    localparam int MAX_SET_BITS = 10;
    localparam int MAX_WAYS = 8;
    localparam int ADDR_WIDTH = 64;
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int OUT_W = ((2 + 10 + 3 + 96 + 7) / 8) * 8;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [9:0]  set_index;
        logic [2:0]  way;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } t_lookup;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [salru_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;

    set_assoc_cache_lru_sim #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS(MAX_WAYS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state.
    logic        line_ok [NSETS][MAX_WAYS];
    logic [63:0] line_tag [NSETS][MAX_WAYS];
    logic [2:0]  line_rank [NSETS][MAX_WAYS];
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;
    logic [3:0]  set_bits_reg, offset_bits_reg, ways_reg;

    logic [63:0] addr_q[$];
    t_lookup     lookup_q[$];
    int errors = 0;
    int cycles = 0;
    int accepted = 0;
    int results = 0;
    bit hold_off = 1'b0;

    task automatic report(input string what, input logic [127:0] got, input logic [127:0] exp);
        $display("mismatch %0s at result %0d: got %0h expected %0h", what, results, got, exp);
        errors++;
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void make_recent(input int st, input int w, input int lim);
        for (int i = 0; i < MAX_WAYS; i++)
            if (i != w && line_ok[st][i] && line_rank[st][i] < lim)
                line_rank[st][i] = line_rank[st][i] + 3'd1;
        line_rank[st][w] = '0;
    endfunction

    function automatic t_lookup predict_lookup(input logic [63:0] addr);
        t_lookup r;
        int sb, ob, ways, st, way;
        logic [63:0] tag;
        bit found;
        sb = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
        ob = offset_bits_reg;
        ways = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
        st = int'((addr >> ob) & ((64'd1 << sb) - 64'd1));
        tag = (ob + sb >= 64) ? 64'd0 : (addr >> (ob + sb));
        r = '0;
        found = 1'b0;
        way = 0;
        for (int w = 0; w < ways && !found; w++)
            if (line_ok[st][w] && line_tag[st][w] == tag) begin
                found = 1'b1;
                way = w;
            end
        if (found) begin
            r.hit = 1'b1;
            hit_cnt = sat_inc(hit_cnt);
            make_recent(st, way, line_rank[st][way]);
        end else begin
            miss_cnt = sat_inc(miss_cnt);
            for (int w = 0; w < ways && !found; w++)
                if (!line_ok[st][w]) begin
                    found = 1'b1;
                    way = w;
                end
            if (found) begin
                make_recent(st, way, MAX_WAYS);
                line_ok[st][way] = 1'b1;
            end else begin
                r.evicted = 1'b1;
                evict_cnt = sat_inc(evict_cnt);
                way = 0;
                for (int i = 1; i < ways; i++)
                    if (line_rank[st][i] > line_rank[st][way])
                        way = i;
                make_recent(st, way, line_rank[st][way]);
            end
            line_tag[st][way] = tag;
        end
        r.set_index = st[9:0];
        r.way = way[2:0];
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        r.evictions = evict_cnt;
        return r;
    endfunction

    task automatic write_reg(input logic [salru_pkg::CFG_IDX_W-1:0] idx,
                             input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            salru_pkg::CFG_SET_BITS: set_bits_reg = val;
            salru_pkg::CFG_OFFSET_BITS: offset_bits_reg = val;
            salru_pkg::CFG_WAYS: ways_reg = val;
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (addr_q.size() != 0 || lookup_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Addresses built from a small tag and set pool so that hits and
    // evictions are frequent.
    function automatic logic [63:0] pick_addr();
        logic [63:0] a;
        int ob, sb;
        ob = offset_bits_reg;
        sb = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        a = 64'($urandom_range(0, 11)) << (ob + sb);
        a |= 64'($urandom_range(0, 3)) << ob;
        a |= 64'($urandom) & ((64'd1 << ob) - 64'd1);
        return a;
    endfunction

    task automatic run_phase(input logic [3:0] sb, input logic [3:0] ob,
                             input logic [3:0] ways, input int count);
        wait_idle();
        write_reg(salru_pkg::CFG_SET_BITS, sb);
        write_reg(salru_pkg::CFG_OFFSET_BITS, ob);
        write_reg(salru_pkg::CFG_WAYS, ways);
        for (int i = 0; i < count; i++) addr_q.push_back(pick_addr());
    endtask

    // Acceptance at the rising edge feeds the predictor.
    bit in_taken = 1'b0;
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            in_taken = 1'b1;
            lookup_q.push_back(predict_lookup(i_s_tdata));
            void'(addr_q.pop_front());
            accepted++;
        end
    end

    // Driver.
    int gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (in_taken) begin
                gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
            end
            if (!i_s_tvalid || in_taken) begin
                if (gap > 0) begin
                    gap--;
                    i_s_tvalid <= 1'b0;
                end else if (addr_q.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= addr_q[0];
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    t_lookup got_r, exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_r = t_lookup'(0);
            got_r.hit = o_m_tdata[0];
            got_r.evicted = o_m_tdata[1];
            got_r.set_index = o_m_tdata[11:2];
            got_r.way = o_m_tdata[14:12];
            got_r.hits = o_m_tdata[46:15];
            got_r.misses = o_m_tdata[78:47];
            got_r.evictions = o_m_tdata[110:79];
            if (lookup_q.size() == 0) begin
                report("unexpected result", got_r, 0);
            end else begin
                exp_r = lookup_q.pop_front();
                if (got_r.hit != exp_r.hit) report("hit", got_r.hit, exp_r.hit);
                if (got_r.evicted != exp_r.evicted)
                    report("evicted", got_r.evicted, exp_r.evicted);
                if (got_r.set_index != exp_r.set_index)
                    report("set_index", got_r.set_index, exp_r.set_index);
                if (got_r.way != exp_r.way) report("way", got_r.way, exp_r.way);
                if (got_r.hits != exp_r.hits) report("hits", got_r.hits, exp_r.hits);
                if (got_r.misses != exp_r.misses)
                    report("misses", got_r.misses, exp_r.misses);
                if (got_r.evictions != exp_r.evictions)
                    report("evictions", got_r.evictions, exp_r.evictions);
            end
            results++;
        end
    end

    int stall = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            i_m_tready <= 1'b0;
        end else if (i_m_tready && o_m_tvalid) begin
            stall = $urandom_range(0, 2) == 0 ? $urandom_range(0, 17) : 0;
            i_m_tready <= (stall == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Long receiver hold-off while addresses keep coming.
    initial begin
        wait (accepted >= 200);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("tb_set_assoc_cache_lru_sim failed");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < MAX_WAYS; w++) begin
                line_ok[s][w] = 1'b0;
                line_tag[s][w] = '0;
                line_rank[s][w] = '0;
            end
        hit_cnt = '0;
        miss_cnt = '0;
        evict_cnt = '0;
        set_bits_reg = salru_pkg::RST_SET_BITS;
        offset_bits_reg = salru_pkg::RST_OFFSET_BITS;
        ways_reg = salru_pkg::RST_WAYS;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset configuration, address extremes, then 4-way
        // thrash of one set to force victim selection and hits.
        addr_q.push_back(64'h0);
        addr_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        addr_q.push_back(64'h0);
        addr_q.push_back(64'h100);
        run_phase(4'd2, 4'd0, 4'd4, 0);
        for (int t = 0; t < 6; t++) addr_q.push_back(64'(t) << 2);
        addr_q.push_back(64'h4);
        addr_q.push_back(64'h8);
        addr_q.push_back(64'h1C);
        // Zero ways, too many set bits, large offset, too many ways.
        run_phase(4'd0, 4'd15, 4'd0, 0);
        addr_q.push_back(64'h8000);
        addr_q.push_back(64'h8000);
        addr_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        run_phase(4'd15, 4'd12, 4'd15, 0);
        addr_q.push_back(64'hFFFF_FFFF_FFFF_F000);
        addr_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
        // Associativity shrinks mid-run; hidden ways keep their lines.
        run_phase(4'd1, 4'd3, 4'd8, 0);
        for (int t = 0; t < 5; t++) addr_q.push_back(64'(t) << 4);
        run_phase(4'd1, 4'd3, 4'd2, 0);
        addr_q.push_back(64'h40);
        addr_q.push_back(64'h00);

        run_phase(4'd4, 4'd4, 4'd8, 150);
        run_phase(4'd10, 4'd12, 4'd1, 80);
        run_phase(4'd0, 4'd0, 4'd3, 80);
        run_phase(4'd3, 4'd6, 4'd4, 120);
        run_phase(4'd7, 4'd2, 4'd8, 100);
        wait_idle();
        if (errors == 0) begin
            $display("tb_set_assoc_cache_lru_sim passed");
        end else begin
            $display("tb_set_assoc_cache_lru_sim failed");
        end
        $finish;
    end

endmodule
